// File: sv/tss_pkg.sv
// Shared types, constants and helpers for the temperature seven-segment scanner.
// No dependencies; used by tss_digit_conv and temperature_seven_segment_scanner.
package tss_pkg;

  localparam int NumDigitsDefault = 4;
  localparam int MaxDigits        = 8;

  localparam int RawW   = 11;   // raw sample, 1/16 degree
  localparam int HundW  = 14;   // hundredths of a degree, max 12794
  localparam int DigitW = 4;
  localparam int SegW   = 8;
  localparam int SelW   = 4;
  localparam int ScanW  = 8;
  localparam int SampW  = 16;
  localparam int PointW = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic [ScanW-1:0]  ScanPeriodRst   = 8'd4;
  localparam logic [SampW-1:0]  SamplePeriodRst = 16'd1001;
  localparam logic [PointW-1:0] PointDigitRst   = 2'd1;

  localparam logic [SegW-1:0] SegPoint = 8'h80;
  localparam logic [SelW-1:0] SelBlank = 4'hF;

  // hex font, bit0 = A .. bit6 = G
  localparam logic [SegW-1:0] SegTable [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  // register index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_SCAN_PERIOD   = 2'd0,
    REG_SAMPLE_PERIOD = 2'd1,
    REG_POINT_DIGIT   = 2'd2
  } reg_idx_e;

  // x / 10^e for x < 2^14, reciprocal multiply with s = 14 + ceil(log2(10^e))
  function automatic logic [HundW-1:0] div_pow10(input logic [HundW-1:0] x, input int e);
    logic [29:0] prod;
    logic [HundW-1:0] q;
    prod = '0;
    q    = '0;
    case (e)
      0: q = x;
      1: begin
        prod = 30'(x) * 30'd26215;
        q    = HundW'(prod >> 18);
      end
      2: begin
        prod = 30'(x) * 30'd20972;
        q    = HundW'(prod >> 21);
      end
      3: begin
        prod = 30'(x) * 30'd16778;
        q    = HundW'(prod >> 24);
      end
      4: begin
        prod = 30'(x) * 30'd26844;
        q    = HundW'(prod >> 28);
      end
      default: q = '0;
    endcase
    return q;
  endfunction

  // decimal digit of weight 10^e
  function automatic logic [DigitW-1:0] digit_at(input logic [HundW-1:0] x, input int e);
    logic [HundW-1:0] qa;
    logic [HundW-1:0] qb;
    logic [HundW-1:0] rem;
    qa  = div_pow10(x, e);
    qb  = div_pow10(x, e + 1);
    rem = qa - ((qb << 3) + (qb << 1));
    return rem[DigitW-1:0];
  endfunction

endpackage

// File: sv/tss_digit_conv.sv
// Raw sample to decimal digits: hundredths = floor((25*raw+2)/4), split per position.
// Depends on tss_pkg.
module tss_digit_conv #(
  parameter int NUM_DIGITS = tss_pkg::NumDigitsDefault
) (
  input  logic [tss_pkg::RawW-1:0]   raw_i,
  output logic [tss_pkg::DigitW-1:0] digits_o [NUM_DIGITS]
);

  logic [tss_pkg::HundW+1:0] scaled;
  logic [tss_pkg::HundW-1:0] hund;

  // 25*raw = 16*raw + 8*raw + raw
  assign scaled = ((tss_pkg::HundW+2)'(raw_i) << 4) + ((tss_pkg::HundW+2)'(raw_i) << 3)
                + (tss_pkg::HundW+2)'(raw_i) + (tss_pkg::HundW+2)'(2);
  assign hund   = scaled[tss_pkg::HundW+1:2];

  // position 0 is most significant
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    assign digits_o[k] = tss_pkg::digit_at(hund, NUM_DIGITS - 1 - k);
  end

endmodule

// File: sv/temperature_seven_segment_scanner.sv
// Top level of the multiplexed seven-segment temperature scanner.
// Depends on tss_pkg and tss_digit_conv.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   opcode_i, raw_temp_i
//   out      out  out_valid_o / out_stall_i segments_o, digit_select_o,
//                                           sample_request_o, display_update_o
//   cfg      in   APB psel/penable/pwrite   paddr (0,4,8), pwdata, prdata
//
// Every input word yields exactly one output word; one per cycle unless stalled.
// All state updates and the result are formed in the cycle a word is accepted
// and land in the output register at the clock edge that accepts it.
// in_stall_o is high only while the output register holds a word that the
// sink is stalling; a word taken at the same edge frees the slot.
// Reset: digits 1,2,3,4, display blank, digit index at the last position,
// counters zero, registers at their defaults. No clearing pass.
module temperature_seven_segment_scanner #(
  parameter int NUM_DIGITS = tss_pkg::NumDigitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [0:0]                  opcode_i,
  input  logic [tss_pkg::RawW-1:0]    raw_temp_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tss_pkg::SegW-1:0]    segments_o,
  output logic [tss_pkg::SelW-1:0]    digit_select_o,
  output logic                        sample_request_o,
  output logic                        display_update_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tss_pkg::AddrW-1:0]   paddr,
  input  logic [tss_pkg::DataW-1:0]   pwdata,
  output logic [tss_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DIGITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tss_pkg::ScanW-1:0]  scan_period_q;
  logic [tss_pkg::SampW-1:0]  sample_period_q;
  logic [tss_pkg::PointW-1:0] point_digit_q;
  logic                       cfg_wr;
  tss_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = tss_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q   <= tss_pkg::ScanPeriodRst;
      sample_period_q <= tss_pkg::SamplePeriodRst;
      point_digit_q   <= tss_pkg::PointDigitRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tss_pkg::REG_SCAN_PERIOD:   scan_period_q   <= pwdata[tss_pkg::ScanW-1:0];
        tss_pkg::REG_SAMPLE_PERIOD: sample_period_q <= pwdata[tss_pkg::SampW-1:0];
        tss_pkg::REG_POINT_DIGIT:   point_digit_q   <= pwdata[tss_pkg::PointW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tss_pkg::REG_SCAN_PERIOD:   prdata = tss_pkg::DataW'(scan_period_q);
      tss_pkg::REG_SAMPLE_PERIOD: prdata = tss_pkg::DataW'(sample_period_q);
      tss_pkg::REG_POINT_DIGIT:   prdata = tss_pkg::DataW'(point_digit_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_accept;
  logic out_take;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_q & ~out_stall_i;

  // ---------------------------------------------------------------------------
  // Sample conversion
  // ---------------------------------------------------------------------------
  logic [tss_pkg::DigitW-1:0] conv_digits [NUM_DIGITS];

  tss_digit_conv #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_conv (
    .raw_i   (raw_temp_i),
    .digits_o(conv_digits)
  );

  // ---------------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------------
  logic [tss_pkg::ScanW-1:0]  tick_count_q, tick_count_d, tick_inc;
  logic [tss_pkg::SampW-1:0]  sample_count_q, sample_count_d;
  logic [IdxW-1:0]            digit_index_q, digit_index_d, digit_next;
  logic [tss_pkg::DigitW-1:0] digit_values_q [NUM_DIGITS];
  logic [tss_pkg::DigitW-1:0] digit_values_d [NUM_DIGITS];
  logic [tss_pkg::SegW-1:0]   seg_latch_q, seg_latch_d, seg_shown;
  logic [tss_pkg::SelW-1:0]   sel_latch_q, sel_latch_d, sel_shown;
  logic                       advance;
  logic                       sample_req_q, update_q;

  assign tick_inc   = tick_count_q + tss_pkg::ScanW'(1);
  assign digit_next = (digit_index_q == LastIdx) ? '0 : digit_index_q + IdxW'(1);

  // pattern of the position about to be shown
  always_comb begin
    seg_shown = tss_pkg::SegTable[digit_values_q[digit_index_q]];
    if (int'(digit_index_q) == int'(point_digit_q)) begin
      seg_shown = seg_shown | tss_pkg::SegPoint;
    end
    // positions with no select line leave the display dark
    for (int b = 0; b < tss_pkg::SelW; b++) begin
      sel_shown[b] = (int'(digit_index_q) != b);
    end
  end

  always_comb begin
    tick_count_d   = tick_count_q;
    sample_count_d = sample_count_q;
    digit_index_d  = digit_index_q;
    digit_values_d = digit_values_q;
    seg_latch_d    = seg_latch_q;
    sel_latch_d    = sel_latch_q;
    advance        = 1'b0;
    if (in_accept) begin
      if (opcode_i == tss_pkg::OP_SAMPLE) begin
        digit_values_d = conv_digits;
        sample_count_d = '0;
      end else begin
        if (sample_count_q != '1) begin
          sample_count_d = sample_count_q + tss_pkg::SampW'(1);
        end
        if (tick_inc >= scan_period_q) begin
          tick_count_d  = '0;
          seg_latch_d   = seg_shown;
          sel_latch_d   = sel_shown;
          digit_index_d = digit_next;
          advance       = 1'b1;
        end else begin
          tick_count_d = tick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q   <= '0;
      sample_count_q <= '0;
      digit_index_q  <= LastIdx;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        digit_values_q[k] <= tss_pkg::DigitW'(k + 1);
      end
      seg_latch_q    <= '0;
      sel_latch_q    <= tss_pkg::SelBlank;
    end else begin
      tick_count_q   <= tick_count_d;
      sample_count_q <= sample_count_d;
      digit_index_q  <= digit_index_d;
      digit_values_q <= digit_values_d;
      seg_latch_q    <= seg_latch_d;
      sel_latch_q    <= sel_latch_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register; the latches double as the segment and select fields
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_req_q <= (sample_count_d >= sample_period_q);
      update_q     <= advance;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segments_o       = seg_latch_q;
  assign digit_select_o   = sel_latch_q;
  assign sample_request_o = sample_req_q;
  assign display_update_o = update_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_sample_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && opcode_i == tss_pkg::OP_SAMPLE) |=> (out_valid_o && !display_update_o))
    else $error("sample word reported a display update");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(digit_index_q) < NUM_DIGITS)
    else $error("digit index out of range");

  a_one_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NUM_DIGITS <= tss_pkg::SelW && out_valid_o && display_update_o)
      |-> ($countones(~digit_select_o) == 1))
    else $error("advance did not select exactly one digit");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for temperature_seven_segment_scanner: drives tick and reading words,
// predicts every display word with a local scan model and checks each field.
// Depends on tss_pkg and the scanner RTL; reads no files.
module tb;

  // One display word as it leaves the block.
  typedef struct packed {
    logic [tss_pkg::SegW-1:0] segments;
    logic [tss_pkg::SelW-1:0] select;
    logic                     request;
    logic                     update;
  } display_word_t;

  localparam logic [tss_pkg::SegW-1:0] DpBit = 8'h80;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [0:0]                 opcode_i;
  logic [tss_pkg::RawW-1:0]   raw_temp_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [tss_pkg::SegW-1:0]   segments_o;
  logic [tss_pkg::SelW-1:0]   digit_select_o;
  logic                       sample_request_o;
  logic                       display_update_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tss_pkg::AddrW-1:0]  paddr;
  logic [tss_pkg::DataW-1:0]  pwdata;
  logic [tss_pkg::DataW-1:0]  prdata;
  logic                       pready;

  temperature_seven_segment_scanner uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .raw_temp_i       (raw_temp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .segments_o       (segments_o),
    .digit_select_o   (digit_select_o),
    .sample_request_o (sample_request_o),
    .display_update_o (display_update_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // Idle percentages for both sides, plus a forced receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          holdoff_cycles = 0;

  // Scan model: register copies and display state.
  logic [tss_pkg::ScanW-1:0]  scan_period_r;
  logic [tss_pkg::SampW-1:0]  sample_period_r;
  logic [tss_pkg::PointW-1:0] point_digit_r;
  logic [7:0]                 tick_cnt;
  logic [15:0]                ticks_since_reading;
  logic [1:0]                 digit_pos;          // next position to show, order 3,0,1,2
  logic [3:0]                 digit_val [4];      // position 0 = thousands
  logic [tss_pkg::SegW-1:0]   seg_latch;
  logic [tss_pkg::SelW-1:0]   sel_latch;
  display_word_t              expected_words [$];

  int mismatch_count = 0;
  int n_ticks = 0;
  int n_readings = 0;
  int n_advances = 0;
  int n_requests = 0;
  int n_reg_writes = 0;
  int n_input_stall_cycles = 0;

  // Hex font, bit0 = A .. bit6 = G.
  function automatic logic [tss_pkg::SegW-1:0] glyph(input logic [3:0] d);
    case (d)
      4'h0: return 8'h3F;
      4'h1: return 8'h06;
      4'h2: return 8'h5B;
      4'h3: return 8'h4F;
      4'h4: return 8'h66;
      4'h5: return 8'h6D;
      4'h6: return 8'h7D;
      4'h7: return 8'h07;
      4'h8: return 8'h7F;
      4'h9: return 8'h6F;
      4'hA: return 8'h77;
      4'hB: return 8'h7C;
      4'hC: return 8'h39;
      4'hD: return 8'h5E;
      4'hE: return 8'h79;
      default: return 8'h71;
    endcase
  endfunction

  function automatic void reset_scan_model();
    scan_period_r       = tss_pkg::ScanPeriodRst;
    sample_period_r     = tss_pkg::SamplePeriodRst;
    point_digit_r       = tss_pkg::PointDigitRst;
    tick_cnt            = '0;
    ticks_since_reading = '0;
    digit_pos           = 2'd3;
    for (int k = 0; k < 4; k++) digit_val[k] = 4'(k + 1);
    seg_latch           = '0;
    sel_latch           = 4'hF;
  endfunction

  // 1/16 degree -> hundredths, rounded: floor((25*raw + 2) / 4)
  function automatic void load_reading(input logic [tss_pkg::RawW-1:0] raw);
    int unsigned hundredths;
    hundredths = 32'(raw);
    hundredths = (25 * hundredths + 2) / 4;
    for (int k = 3; k >= 0; k--) begin
      digit_val[k] = 4'(hundredths % 10);
      hundredths   = hundredths / 10;
    end
  endfunction

  // Apply one accepted word to the model and queue the display word it yields.
  function automatic void advance_scan_model(input tss_pkg::opcode_e op,
                                             input logic [tss_pkg::RawW-1:0] raw);
    display_word_t w;
    w.update = 1'b0;
    if (op == tss_pkg::OP_SAMPLE) begin
      load_reading(raw);
      ticks_since_reading = '0;
      n_readings++;
    end else begin
      n_ticks++;
      if (ticks_since_reading != 16'hFFFF) ticks_since_reading++;
      tick_cnt++;
      if (tick_cnt >= scan_period_r) begin
        tick_cnt  = '0;
        seg_latch = glyph(digit_val[digit_pos]) |
                    ((digit_pos == point_digit_r) ? DpBit : 8'h00);
        sel_latch = ~(4'b0001 << digit_pos);
        digit_pos++;
        w.update  = 1'b1;
        n_advances++;
      end
    end
    w.segments = seg_latch;
    w.select   = sel_latch;
    w.request  = (ticks_since_reading >= sample_period_r);
    if (w.request) n_requests++;
    expected_words.push_back(w);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want_v);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want_v);
  endtask

  // Output checker: every accepted word is matched against the oldest prediction.
  display_word_t want;
  always @(posedge clk_i) begin
    if (rst_ni && in_stall_o) n_input_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("word with none expected", 32'(segments_o), 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (segments_o !== want.segments)
          flag_mismatch("segments", 32'(segments_o), 32'(want.segments));
        if (digit_select_o !== want.select)
          flag_mismatch("digit_select", 32'(digit_select_o), 32'(want.select));
        if (sample_request_o !== want.request)
          flag_mismatch("sample_request", 32'(sample_request_o), 32'(want.request));
        if (display_update_o !== want.update)
          flag_mismatch("display_update", 32'(display_update_o), 32'(want.update));
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles > 0) begin
        out_stall_i <= 1'b1;
        holdoff_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Send one word; valid stays up until the block takes it.
  task automatic send_word(input tss_pkg::opcode_e op, input logic [tss_pkg::RawW-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i   <= op;
    raw_temp_i <= raw;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    advance_scan_model(op, raw);
  endtask

  // Every word yields a result, so an empty queue means the block is idle.
  task automatic finish_outstanding();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input tss_pkg::reg_idx_e idx, input logic [tss_pkg::DataW-1:0] value);
    finish_outstanding();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tss_pkg::REG_SCAN_PERIOD:   scan_period_r   = value[tss_pkg::ScanW-1:0];
      tss_pkg::REG_SAMPLE_PERIOD: sample_period_r = value[tss_pkg::SampW-1:0];
      tss_pkg::REG_POINT_DIGIT:   point_digit_r   = value[tss_pkg::PointW-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Raw readings lean a little toward the ends of the range.
  function automatic logic [tss_pkg::RawW-1:0] pick_raw();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return tss_pkg::RawW'($urandom);
    endcase
  endfunction

  // Defaults after reset: digits 1,2,3,4, advance every 4 ticks, point on position 1.
  task automatic test_reset_display();
    send_idle_pct = 27;
    recv_idle_pct = 49;
    repeat (9) send_word(tss_pkg::OP_TICK, pick_raw());
  endtask

  // Largest and smallest readings, one full scan after each, point moved to ends.
  task automatic test_reading_extremes();
    write_reg(tss_pkg::REG_SCAN_PERIOD, 1);
    write_reg(tss_pkg::REG_POINT_DIGIT, 3);
    send_word(tss_pkg::OP_SAMPLE, 11'h7FF);
    repeat (4) send_word(tss_pkg::OP_TICK, 11'h000);
    write_reg(tss_pkg::REG_POINT_DIGIT, 0);
    send_word(tss_pkg::OP_SAMPLE, 11'h000);
    repeat (4) send_word(tss_pkg::OP_TICK, 11'h7FF);
  endtask

  // Zero periods: advance on every tick, request held high even right after a reading.
  task automatic test_zero_periods();
    write_reg(tss_pkg::REG_SCAN_PERIOD, 0);
    write_reg(tss_pkg::REG_SAMPLE_PERIOD, 0);
    write_reg(tss_pkg::REG_POINT_DIGIT, 2);
    send_word(tss_pkg::OP_SAMPLE, 11'd1365);
    repeat (4) send_word(tss_pkg::OP_TICK, pick_raw());
  endtask

  // Longest scan period: the tick counter climbs to 254 before the first advance,
  // and the request rises once the reading is old enough.
  task automatic test_count_saturation();
    write_reg(tss_pkg::REG_SCAN_PERIOD, 8'd255);
    write_reg(tss_pkg::REG_SAMPLE_PERIOD, 16'd200);
    send_word(tss_pkg::OP_SAMPLE, pick_raw());
    repeat (260) send_word(tss_pkg::OP_TICK, tss_pkg::RawW'($urandom));
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // output register fills and the input stalls.
  task automatic test_output_backpressure();
    write_reg(tss_pkg::REG_SCAN_PERIOD, 1);
    write_reg(tss_pkg::REG_SAMPLE_PERIOD, 5);
    holdoff_cycles = 40;
    send_word(tss_pkg::OP_SAMPLE, 11'd1234);
    repeat (20) send_word(tss_pkg::OP_TICK, tss_pkg::RawW'($urandom));
  endtask

  // Mostly reading cycles (a reading, then a run of 0 to 2*sample_period+3
  // ticks that may end before the request rises), some single random words.
  task automatic run_random_phase(input int n_words, input int scan_hi, input int samp_hi);
    int sent;
    int burst;
    sent = 0;
    write_reg(tss_pkg::REG_SCAN_PERIOD, $urandom_range(scan_hi, 1));
    write_reg(tss_pkg::REG_SAMPLE_PERIOD, $urandom_range(samp_hi, 1));
    write_reg(tss_pkg::REG_POINT_DIGIT, $urandom_range(3));
    while (sent < n_words) begin
      if ($urandom_range(99) < 80) begin
        send_word(tss_pkg::OP_SAMPLE, pick_raw());
        sent++;
        burst = $urandom_range(2 * int'(sample_period_r) + 3);
        for (int i = 0; i < burst && sent < n_words; i++) begin
          send_word(tss_pkg::OP_TICK, tss_pkg::RawW'($urandom));
          sent++;
        end
      end else begin
        send_word(tss_pkg::opcode_e'($urandom_range(1)), pick_raw());
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 27;
    recv_idle_pct = 49;
    run_random_phase(100, 4, 20);
    run_random_phase(90, 12, 60);
    send_idle_pct = 49;
    recv_idle_pct = 27;
    run_random_phase(90, 4, 20);
    run_random_phase(90, 12, 60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(90, 4, 20);
    run_random_phase(90, 12, 60);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = tss_pkg::OP_TICK;
    raw_temp_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    reset_scan_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_display();
    test_reading_extremes();
    test_zero_periods();
    test_output_backpressure();
    test_count_saturation();
    test_random_traffic();

    finish_outstanding();
    repeat (4) @(posedge clk_i);
    if (expected_words.size() != 0)
      flag_mismatch("words never delivered", 32'(expected_words.size()), 32'd0);

    $display("Covered %0d ticks, %0d readings, %0d digit advances, %0d words with request.",
             n_ticks, n_readings, n_advances, n_requests);
    $display("Made %0d register writes; input stalled %0d cycles; %0d mismatches.",
             n_reg_writes, n_input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a correct run finishes well before this fires.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
